/* design/rhh_pkg.sv */
`default_nettype none

package rhh_pkg;

	// Field widths fixed by the word formats.
	localparam int KEY_W  = 32;
	localparam int SLOT_W = 6;
	localparam int LEN_W  = 7;
	localparam int CMD_W  = 2;

	// Default physical table depth and reset value of the length register.
	localparam int MAX_SLOTS_DEF = 64;
	localparam logic [LEN_W-1:0] TABLE_LEN_RST = 7'd64;

	// The modulo unit retires this many dividend bits per cycle.
	localparam int MOD_STEP  = 8;
	localparam int MOD_CYC   = KEY_W / MOD_STEP;
	localparam int MOD_CNT_W = $clog2(MOD_CYC);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

	// Request word.
	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot_index;
	} rhh_in_t;

	// Response word.
	typedef struct packed {
		logic              status;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key_out;
		logic              occupied;
		logic [LEN_W-1:0]  probes;
	} rhh_out_t;

	// Modulo unit request and response.
	typedef struct packed {
		logic              start;
		logic [LEN_W-1:0]  divisor;
		logic [KEY_W-1:0]  dividend;
	} rhh_mod_req_t;

	typedef struct packed {
		logic              done;
		logic [SLOT_W-1:0] rem;
	} rhh_mod_rsp_t;

endpackage

`default_nettype wire

/* design/rhh_ram.sv */
`default_nettype none

module rhh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/rhh_mod.sv */
`default_nettype none

module rhh_mod import rhh_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rhh_mod_req_t req,
	output rhh_mod_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]     dq_q;
	logic [SLOT_W-1:0]    r_q;
	logic [LEN_W-1:0]     div_q;
	logic [SLOT_W-1:0]    r_nxt;

	// Restoring reduction of the next group of dividend bits, MSB first.
	// The partial remainder stays below the divisor, which is at most 64.
	always_comb begin
		logic [LEN_W-1:0] t;
		t = '0;
		r_nxt = r_q;
		for (int i = 0; i < MOD_STEP; i++) begin
			t = {r_nxt, dq_q[KEY_W-1-i]};
			if (t >= div_q) begin
				t = t - div_q;
			end
			r_nxt = t[SLOT_W-1:0];
		end
	end

	// Control: busy after a start until the last group of dividend bits is reduced, then a done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath: dividend shifter and partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= req.dividend;
			div_q <= req.divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dq_q <= dq_q << MOD_STEP;
			r_q  <= r_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

`default_nettype wire

/* design/robin_hood_hash_insert.sv */
// Steps from acceptance to response valid. Insert: hash the key in the modulo unit, then for
// each occupied slot probed a RAM read, a load and a modulo of the resident key up to its
// done pulse, then a write at the free slot and a stage for the response; a drop comes after
// every slot in use has been probed. Read adds a RAM read when the slot is occupied; clear
// and the unused command go straight to the response stage. The next word can be accepted as
// soon as the response is valid. Reset clears the valid flops and sets the length to 64.
`default_nettype none

module robin_hood_hash_insert import rhh_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [LEN_W-1:0] cfg_wdata,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire rhh_in_t          req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rhh_out_t              rsp
);

	localparam int AW   = $clog2(MAX_SLOTS);
	localparam int USED = (MAX_SLOTS < (1 << SLOT_W)) ? MAX_SLOTS : (1 << SLOT_W);
	localparam int VW   = $clog2(USED);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_HOME  = 7'b0000010,
		ST_PROBE = 7'b0000100,
		ST_LOAD  = 7'b0001000,
		ST_RMOD  = 7'b0010000,
		ST_RDW   = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  table_len_q;
	logic [USED-1:0]   valid_q;
	logic              rsp_valid_q;
	rhh_out_t          rsp_q;
	rhh_out_t          fin_q;
	logic [KEY_W-1:0]  carry_q;
	logic [KEY_W-1:0]  res_q;
	logic [SLOT_W-1:0] home_q;
	logic [SLOT_W-1:0] pos_q;
	logic [LEN_W-1:0]  j_q;
	logic [LEN_W-1:0]  n_q;

	logic [LEN_W-1:0]  eff_len;
	logic              acc;
	logic              out_free;
	logic              rd_occ;
	logic              hit_empty;
	logic              swap;
	logic [SLOT_W-1:0] carry_gap;
	logic [SLOT_W-1:0] res_gap;
	logic [LEN_W-1:0]  pos_inc;
	logic [SLOT_W-1:0] pos_nxt;
	logic [LEN_W-1:0]  j_inc;
	logic [KEY_W-1:0]  carry_new;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [KEY_W-1:0]  ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [KEY_W-1:0]  ram_rdata;

	rhh_mod_req_t      mod_req;
	rhh_mod_rsp_t      mod_rsp;

	// Distance of a slot from a home slot, wrapping at the table length.
	function automatic logic [SLOT_W-1:0] gap(
		input logic [SLOT_W-1:0] pos,
		input logic [SLOT_W-1:0] home,
		input logic [LEN_W-1:0]  n
	);
		logic [LEN_W-1:0] d;
		if (pos >= home) begin
			d = {1'b0, pos} - {1'b0, home};
		end else begin
			d = {1'b0, pos} + n - {1'b0, home};
		end
		return d[SLOT_W-1:0];
	endfunction

	rhh_ram #(
		.WIDTH (KEY_W),
		.DEPTH (MAX_SLOTS)
	) u_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rhh_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// Length in use: zero counts as one, and it never exceeds the addressable table.
	always_comb begin
		if (table_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (int'(table_len_q) > USED) begin
			eff_len = LEN_W'(USED);
		end else begin
			eff_len = table_len_q;
		end
	end

	// Handshake and probe decisions.
	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rd_occ    = (int'(req.slot_index) < USED) && valid_q[req.slot_index[VW-1:0]];
	assign hit_empty = !valid_q[pos_q[VW-1:0]];
	assign carry_gap = gap(pos_q, home_q, n_q);
	assign res_gap   = gap(pos_q, mod_rsp.rem, n_q);
	assign swap      = carry_gap > res_gap;
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign pos_nxt   = (pos_inc == n_q) ? '0 : pos_inc[SLOT_W-1:0];
	assign j_inc     = j_q + 1'b1;
	assign carry_new = swap ? res_q : carry_q;

	// Memory and modulo unit requests.
	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = AW'(pos_q);
		ram_wdata        = carry_q;
		ram_re           = 1'b0;
		ram_raddr        = AW'(pos_q);
		mod_req.start    = 1'b0;
		mod_req.divisor  = n_q;
		mod_req.dividend = ram_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.cmd == CMD_INSERT) begin
					mod_req.start    = 1'b1;
					mod_req.divisor  = eff_len;
					mod_req.dividend = req.key;
				end
				if (acc && req.cmd == CMD_READ && rd_occ) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(req.slot_index);
				end
			end
			ST_PROBE: begin
				if (hit_empty) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			ST_LOAD: begin
				mod_req.start = 1'b1;
			end
			ST_RMOD: begin
				if (mod_rsp.done && swap) begin
					ram_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, length register, valid flops, output flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			table_len_q <= TABLE_LEN_RST;
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_len_q <= cfg_wdata;
			end
			if (state_q == ST_FIN && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.cmd)
							CMD_INSERT: state_q <= ST_HOME;
							CMD_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_FIN;
							end
							CMD_READ: state_q <= rd_occ ? ST_RDW : ST_FIN;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_HOME: begin
					if (mod_rsp.done) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (hit_empty) begin
						valid_q[pos_q[VW-1:0]] <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_RMOD;
				ST_RMOD: begin
					if (mod_rsp.done) begin
						state_q <= (j_inc == n_q) ? ST_FIN : ST_PROBE;
					end
				end
				ST_RDW: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: carried key, probe position, staged and delivered responses.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					carry_q <= req.key;
					n_q     <= eff_len;
					if (req.cmd == CMD_READ) begin
						fin_q <= '{status: 1'b0, slot: req.slot_index, key_out: '0,
							occupied: rd_occ, probes: '0};
					end else begin
						fin_q <= '0;
					end
				end
			end
			ST_HOME: begin
				if (mod_rsp.done) begin
					home_q <= mod_rsp.rem;
					pos_q  <= mod_rsp.rem;
					j_q    <= '0;
				end
			end
			ST_PROBE: begin
				if (hit_empty) begin
					fin_q <= '{status: 1'b0, slot: pos_q, key_out: carry_q,
						occupied: 1'b1, probes: j_inc};
				end
			end
			ST_LOAD: res_q <= ram_rdata;
			ST_RMOD: begin
				if (mod_rsp.done) begin
					if (swap) begin
						carry_q <= res_q;
						home_q  <= mod_rsp.rem;
					end
					pos_q <= pos_nxt;
					j_q   <= j_inc;
					// Drop response; replaced if a later probe stores the key.
					fin_q <= '{status: 1'b1, slot: '0, key_out: carry_new,
						occupied: 1'b0, probes: n_q};
				end
			end
			ST_RDW: fin_q.key_out <= ram_rdata;
			ST_FIN: begin
				if (out_free) begin
					rsp_q <= fin_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A key write never lands outside the slots in use.
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ({1'b0, pos_q} < n_q))
		else $error("key write outside the table length");

	// The probe count stays below the length while probing.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PROBE) |-> (j_q < n_q))
		else $error("probe count reached the table length");

	// A finished modulo is always a valid slot of the current length.
	a_mod_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mod_rsp.done && (state_q == ST_HOME || state_q == ST_RMOD))
			|-> ({1'b0, mod_rsp.rem} < n_q))
		else $error("modulo result not below the table length");

endmodule

`default_nettype wire

/* dv/robin_hood_hash_insert_tb.sv */
`default_nettype none

module robin_hood_hash_insert_tb import rhh_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 8000;
	localparam int LONG_HOLD  = 700;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	rhh_in_t          req = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rhh_out_t         rsp;

	// Shadow copy of the table and the length register.
	bit [KEY_W-1:0]   shadow_keys [MAX_SLOTS_DEF];
	bit               shadow_valid [MAX_SLOTS_DEF];
	bit [LEN_W-1:0]   shadow_len = TABLE_LEN_RST;

	rhh_out_t         pending_rsp [$];
	int               errors = 0;
	bit               src_gaps = 1'b1;
	bit               sink_gaps = 1'b1;
	int               hold_request = 0;
	int               hold_left = 0;
	int               idle_cycles = 0;

	robin_hood_hash_insert dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Applies one request word to the shadow table and returns the response it should give.
	function automatic rhh_out_t robin_hood_apply(input rhh_in_t w);
		rhh_out_t       r;
		int unsigned    n;
		int unsigned    home;
		int unsigned    res_home;
		int unsigned    pos;
		int unsigned    j;
		bit [KEY_W-1:0] carry;
		bit [KEY_W-1:0] res;
		bit             placed;
		r = '0;
		case (w.cmd)
			CMD_INSERT: begin
				// A length of zero acts as one, and anything past the table acts as the full table.
				n = (shadow_len == 0) ? 1 : shadow_len;
				if (n > MAX_SLOTS_DEF)
					n = MAX_SLOTS_DEF;
				carry = w.key;
				home = carry % n;
				pos = home;
				placed = 1'b0;
				for (j = 0; j < n; j++) begin
					if (!shadow_valid[pos]) begin
						shadow_keys[pos] = carry;
						shadow_valid[pos] = 1'b1;
						placed = 1'b1;
						break;
					end
					// The key that is further from home takes the slot.
					res = shadow_keys[pos];
					res_home = res % n;
					if (((pos + n - home) % n) > ((pos + n - res_home) % n)) begin
						shadow_keys[pos] = carry;
						carry = res;
						home = res_home;
					end
					pos = (pos + 1) % n;
				end
				r.key_out = carry;
				if (placed) begin
					r.slot = SLOT_W'(pos);
					r.occupied = 1'b1;
					r.probes = LEN_W'(j + 1);
				end else begin
					r.status = 1'b1;
					r.probes = LEN_W'(n);
				end
			end
			CMD_CLEAR: begin
				shadow_valid = '{default: 1'b0};
			end
			CMD_READ: begin
				r.slot = w.slot_index;
				if (shadow_valid[w.slot_index]) begin
					r.occupied = 1'b1;
					r.key_out = shadow_keys[w.slot_index];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
			input logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("field %s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Offers one word, with an optional gap first, and records its expected response.
	task automatic send_word(input rhh_in_t w);
		int       gap_len;
		rhh_out_t expect_rsp;
		gap_len = 0;
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 4) == 0)
			gap_len = $urandom_range(1, 18);
		if (gap_len > 0) begin
			req_valid <= 1'b0;
			repeat (gap_len) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (!req_ready);
		expect_rsp = robin_hood_apply(w);
		pending_rsp = {pending_rsp, expect_rsp};
	endtask

	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [SLOT_W-1:0] idx);
		rhh_in_t w;
		w.cmd = cmd;
		w.key = key;
		w.slot_index = idx;
		send_word(w);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// The length register is only written once every response is back.
	task automatic write_len(input logic [LEN_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_len = value;
	endtask

	function automatic rhh_in_t random_word(input int unsigned key_span);
		rhh_in_t     w;
		int unsigned pick;
		w.key = (key_span != 0 && $urandom_range(0, 1) == 0) ?
			$urandom_range(0, key_span) : $urandom;
		w.slot_index = SLOT_W'($urandom_range(0, 63));
		pick = $urandom_range(0, 99);
		if (pick < 74)
			w.cmd = CMD_INSERT;
		else if (pick < 95)
			w.cmd = CMD_READ;
		else if (pick < 98)
			w.cmd = CMD_CLEAR;
		else
			w.cmd = CMD_RSVD;
		return w;
	endfunction

	task automatic test_insert_and_read();
		int i;
		send_cmd(CMD_READ, '0, 6'd0);
		send_cmd(CMD_READ, '1, 6'd63);
		send_cmd(CMD_INSERT, 32'd0, '1);
		send_cmd(CMD_INSERT, 32'hFFFF_FFFF, '0);
		send_cmd(CMD_INSERT, 32'd64, '0);
		send_cmd(CMD_INSERT, 32'd1, '0);
		// This key travels far enough to displace a resident that sits nearer its home.
		send_cmd(CMD_INSERT, 32'd128, '0);
		for (i = 0; i < 4; i++)
			send_cmd(CMD_READ, '0, SLOT_W'(i));
		send_cmd(CMD_READ, '0, 6'd63);
	endtask

	task automatic test_clear_and_unused();
		send_cmd(CMD_RSVD, 32'hFFFF_FFFF, 6'd63);
		send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 6'd63);
		send_cmd(CMD_READ, '0, 6'd0);
	endtask

	task automatic test_length_extremes();
		write_len(7'd64);
		send_cmd(CMD_INSERT, 32'd63, '0);
		// Zero acts as a one-slot table; the key in slot 63 stays visible to reads.
		write_len(7'd0);
		send_cmd(CMD_INSERT, 32'd5, '0);
		send_cmd(CMD_INSERT, 32'd7, '0);
		send_cmd(CMD_READ, '0, 6'd63);
		write_len(7'd127);
		send_cmd(CMD_INSERT, 32'd1, '0);
		write_len(7'd1);
		send_cmd(CMD_INSERT, 32'd9, '0);
	endtask

	// The receiver holds off while words keep coming, so the input backs up.
	task automatic test_backpressure();
		int i;
		write_len(7'd16);
		hold_request = LONG_HOLD;
		for (i = 0; i < 12; i++)
			send_word(random_word(48));
		wait_drained();
	endtask

	task automatic test_random_phase(input logic [LEN_W-1:0] len_value, input int count,
			input int unsigned key_span);
		int i;
		write_len(len_value);
		send_cmd(CMD_CLEAR, '0, '0);
		for (i = 0; i < count; i++)
			send_word(random_word(key_span));
	endtask

	task automatic test_steady_stream();
		wait_drained();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		test_random_phase(7'd9, 100, 40);
	endtask

	// Receiver: random stall bursts, plus the long hold that a test can ask for.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left == 0 && sink_gaps && $urandom_range(0, 5) == 0)
			hold_left = $urandom_range(1, 18);
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Compare each accepted response word with the oldest expectation.
	always @(posedge clk) begin
		rhh_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsp.size() == 0) begin
				$error("response word with nothing expected: %p", rsp);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", want.status, rsp.status);
				check_field("slot", want.slot, rsp.slot);
				check_field("key_out", want.key_out, rsp.key_out);
				check_field("occupied", want.occupied, rsp.occupied);
				check_field("probes", want.probes, rsp.probes);
			end
		end
	end

	// Watchdog on cycles with no word moving on either side.
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("robin_hood_hash_insert_tb failed");
		$finish;
	end

	initial begin
		shadow_keys = '{default: '0};
		shadow_valid = '{default: 1'b0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_insert_and_read();
		test_clear_and_unused();
		test_length_extremes();
		test_backpressure();
		test_random_phase(7'd3, 70, 12);
		test_random_phase(7'd64, 140, 1023);
		test_random_phase(7'd0, 25, 8);
		test_random_phase(7'd100, 60, 300);
		test_random_phase(7'd17, 70, 60);
		test_random_phase(7'd2, 35, 10);
		test_steady_stream();

		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_rsp.size() == 0)
			$display("robin_hood_hash_insert_tb passed");
		else
			$display("robin_hood_hash_insert_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
design/rhh_pkg.sv
design/rhh_ram.sv
design/rhh_mod.sv
design/robin_hood_hash_insert.sv
dv/robin_hood_hash_insert_tb.sv
